// ----- rtl/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants for the ray/box slab intersect block
// Coordinate widths, parameter defaults and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int T_FRAC_BITS_DEF     = 16;

  localparam int COORD_W   = 32;
  localparam int HALF_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int AXES      = 3;
  localparam int FRACS     = 2 * AXES;

  // signed width that holds every coordinate, half extent and difference
  localparam int WIDE_W = COORD_W + 2;
  // magnitude width of slab numerators and denominators
  localparam int MAG_W  = COORD_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/ray_box_slab_intersect_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: segment versus centered box, slab method
// Pipelined test of one segment per cycle against a box of configurable
// half extents; gives hit flag, entry fraction and interpolated hit point.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   in       | in_valid / in_ready  | start_x/y/z, end_x/y/z (Q16.16)
//   out      | out_valid / out_ready| hit, hit_t, hit_point_x/y/z
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (half extents)
//
// One word per cycle sustained while out_ready holds; stages are front, six
// restoring dividers (one quotient bit per stage), reduce, multiply, output.
// Reset clears all stage valid bits and loads half extents of 1.0.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and in_ready drops only when the whole pipe is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect_top
  import rbsi_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int T_FRAC_BITS     = T_FRAC_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,

  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [CFG_IDX_W-1:0]        cfg_index,
  input  wire  [HALF_W-1:0]           cfg_data,

  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  signed [COORD_W-1:0]   in_start_x,
  input  wire  signed [COORD_W-1:0]   in_start_y,
  input  wire  signed [COORD_W-1:0]   in_start_z,
  input  wire  signed [COORD_W-1:0]   in_end_x,
  input  wire  signed [COORD_W-1:0]   in_end_y,
  input  wire  signed [COORD_W-1:0]   in_end_z,

  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_hit,
  output logic [T_FRAC_BITS:0]        out_hit_t,
  output logic signed [COORD_W-1:0]   out_hit_point_x,
  output logic signed [COORD_W-1:0]   out_hit_point_y,
  output logic signed [COORD_W-1:0]   out_hit_point_z
);

  localparam int N    = T_FRAC_BITS;
  localparam int TW   = N + 1;
  localparam int NS   = N + 4;
  localparam int S_RD = N + 1;
  localparam int S_ML = N + 2;
  localparam int S_OU = N + 3;
  localparam int PW   = MAG_W + N + 2;
  localparam logic [TW-1:0] T_ONE = TW'(1) << N;
  localparam logic [HALF_W-1:0] HALF_RST = HALF_W'(1) << COORD_FRAC_BITS;

  // configuration
  logic [HALF_W-1:0] half_r [AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) half_r[i] <= HALF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_X: half_r[0] <= cfg_data;
        REG_HALF_Y: half_r[1] <= cfg_data;
        REG_HALF_Z: half_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // front stage plus divider stages 1..N share these carry registers
  logic signed [COORD_W-1:0] s_r   [N+1][AXES];
  logic signed [MAG_W-1:0]   dif_r [N+1][AXES];
  logic                      rej_r [N+1];
  logic                      fz_r  [N+1][FRACS];
  logic                      fo_r  [N+1][FRACS];
  logic [MAG_W-1:0]          den_r [N+1][FRACS];
  logic [MAG_W-1:0]          rem_r [N+1][FRACS];
  logic [N-1:0]              q_r   [N+1][FRACS];

  logic signed [COORD_W-1:0] s_in [AXES];
  logic signed [COORD_W-1:0] e_in [AXES];

  assign s_in[0] = in_start_x;
  assign s_in[1] = in_start_y;
  assign s_in[2] = in_start_z;
  assign e_in[0] = in_end_x;
  assign e_in[1] = in_end_y;
  assign e_in[2] = in_end_z;

  logic signed [MAG_W-1:0] dif_nxt [AXES];
  logic                    rej_nxt;
  logic                    fz_nxt  [FRACS];
  logic                    fo_nxt  [FRACS];
  logic [MAG_W-1:0]        num_nxt [FRACS];
  logic [MAG_W-1:0]        den_nxt [FRACS];

  always_comb begin
    logic signed [WIDE_W-1:0] sx, ex, hi, lo, d, stn, etn;
    logic                     up, rej, stc, etc;
    rej_nxt = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      sx = WIDE_W'(s_in[i]);
      ex = WIDE_W'(e_in[i]);
      hi = $signed({3'b000, half_r[i]});
      lo = -hi;
      up = sx < ex;
      if (up) begin
        rej = (sx > hi) || (ex < lo);
        d   = ex - sx;
        stc = sx < lo;
        stn = lo - sx;
        etc = ex > hi;
        etn = hi - sx;
      end else begin
        rej = (ex > hi) || (sx < lo);
        d   = sx - ex;
        stc = sx > hi;
        stn = sx - hi;
        etc = ex < lo;
        etn = sx - lo;
      end
      rej_nxt        = rej_nxt || rej;
      dif_nxt[i]     = MAG_W'(ex - sx);
      fz_nxt[2*i]    = !stc || (stn <= 0);
      fo_nxt[2*i]    = stc && (stn > 0) && (stn >= d);
      num_nxt[2*i]   = stn[MAG_W-1:0];
      den_nxt[2*i]   = d[MAG_W-1:0];
      fz_nxt[2*i+1]  = etc && (etn <= 0);
      fo_nxt[2*i+1]  = !etc || ((etn > 0) && (etn >= d));
      num_nxt[2*i+1] = etn[MAG_W-1:0];
      den_nxt[2*i+1] = d[MAG_W-1:0];
    end
  end

  // one restoring quotient bit per stage
  logic [MAG_W-1:0] rem_nxt [1:N][FRACS];
  logic [N-1:0]     q_nxt   [1:N][FRACS];

  always_comb begin
    logic [MAG_W:0] t;
    for (int k = 1; k <= N; k++) begin
      for (int j = 0; j < FRACS; j++) begin
        t = {rem_r[k-1][j], 1'b0};
        if (t >= {1'b0, den_r[k-1][j]}) begin
          rem_nxt[k][j] = MAG_W'(t - {1'b0, den_r[k-1][j]});
          q_nxt[k][j]   = {q_r[k-1][j][N-2:0], 1'b1};
        end else begin
          rem_nxt[k][j] = t[MAG_W-1:0];
          q_nxt[k][j]   = {q_r[k-1][j][N-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rej_r[0] <= rej_nxt;
      for (int i = 0; i < AXES; i++) begin
        s_r[0][i]   <= s_in[i];
        dif_r[0][i] <= dif_nxt[i];
      end
      for (int j = 0; j < FRACS; j++) begin
        fz_r[0][j]  <= fz_nxt[j];
        fo_r[0][j]  <= fo_nxt[j];
        den_r[0][j] <= den_nxt[j];
        rem_r[0][j] <= num_nxt[j];
        q_r[0][j]   <= '0;
      end
    end
    for (int k = 1; k <= N; k++) begin
      if (rdy[k]) begin
        rej_r[k] <= rej_r[k-1];
        for (int i = 0; i < AXES; i++) begin
          s_r[k][i]   <= s_r[k-1][i];
          dif_r[k][i] <= dif_r[k-1][i];
        end
        for (int j = 0; j < FRACS; j++) begin
          fz_r[k][j]  <= fz_r[k-1][j];
          fo_r[k][j]  <= fo_r[k-1][j];
          den_r[k][j] <= den_r[k-1][j];
          rem_r[k][j] <= rem_nxt[k][j];
          q_r[k][j]   <= q_nxt[k][j];
        end
      end
    end
  end

  // reduce: running entry is max of entries, exit is min of exits
  logic                      rd_hit_r;
  logic [TW-1:0]             rd_ent_r;
  logic signed [COORD_W-1:0] rd_s_r   [AXES];
  logic signed [MAG_W-1:0]   rd_dif_r [AXES];
  logic                      rd_hit_nxt;
  logic [TW-1:0]             rd_ent_nxt;

  always_comb begin
    logic [TW-1:0] fr [FRACS];
    logic [TW-1:0] lv;
    for (int j = 0; j < FRACS; j++) begin
      priority if (fz_r[N][j]) fr[j] = '0;
      else if (fo_r[N][j])     fr[j] = T_ONE;
      else                     fr[j] = {1'b0, q_r[N][j]};
    end
    rd_ent_nxt = '0;
    lv         = T_ONE;
    for (int i = 0; i < AXES; i++) begin
      if (fr[2*i] > rd_ent_nxt) rd_ent_nxt = fr[2*i];
      if (fr[2*i+1] < lv)       lv = fr[2*i+1];
    end
    rd_hit_nxt = !rej_r[N] && (lv >= rd_ent_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy[S_RD]) begin
      rd_hit_r <= rd_hit_nxt;
      rd_ent_r <= rd_ent_nxt;
      for (int i = 0; i < AXES; i++) begin
        rd_s_r[i]   <= s_r[N][i];
        rd_dif_r[i] <= dif_r[N][i];
      end
    end
  end

  // multiply: (end - start) * t
  logic                      ml_hit_r;
  logic [TW-1:0]             ml_ent_r;
  logic signed [COORD_W-1:0] ml_s_r    [AXES];
  logic signed [PW-1:0]      ml_prod_r [AXES];

  always_ff @(posedge clk) begin
    if (rdy[S_ML]) begin
      ml_hit_r <= rd_hit_r;
      ml_ent_r <= rd_ent_r;
      for (int i = 0; i < AXES; i++) begin
        ml_s_r[i]    <= rd_s_r[i];
        ml_prod_r[i] <= PW'(rd_dif_r[i] * $signed({1'b0, rd_ent_r}));
      end
    end
  end

  // output word: floor shift and add, zeros on a miss
  logic signed [COORD_W-1:0] pt_nxt [AXES];

  always_comb begin
    logic signed [PW-1:0] q;
    for (int i = 0; i < AXES; i++) begin
      q         = ml_prod_r[i] >>> N;
      pt_nxt[i] = ml_hit_r ? (ml_s_r[i] + COORD_W'(q)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OU]) begin
      out_hit         <= ml_hit_r;
      out_hit_t       <= ml_hit_r ? ml_ent_r : '0;
      out_hit_point_x <= pt_nxt[0];
      out_hit_point_y <= pt_nxt[1];
      out_hit_point_z <= pt_nxt[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("in_ready low with room in the pipe");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_t == '0 && out_hit_point_x == '0)
    else $error("miss word carries nonzero payload");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_t <= T_ONE)
    else $error("hit_t above 1.0");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted word not in front stage");
`endif

endmodule

`default_nettype wire
